[hw/rtl/bod_pkg.sv]
// ----------------------------------------------------------------------------
// bod_pkg
// shared types and constants of the byte-offset delta decoder
// ----------------------------------------------------------------------------
`default_nettype none

package bod_pkg;

	// escape level of the parser: width of the delta being gathered
	typedef enum logic [1:0] {
		ESC_8  = 2'd0,
		ESC_16 = 2'd1,
		ESC_32 = 2'd2,
		ESC_64 = 2'd3
	} esc_level_t;

	typedef logic [31:0] delta_t;

	// one finished delta moving between the parts
	typedef struct packed {
		logic   valid;
		delta_t delta;
	} delta_word_t;

	localparam int COUNT_W  = 25;
	localparam int PIXELS_W = 24;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 25'h100_0000;
	localparam logic [COUNT_W-1:0] COUNT_MIN = 25'd1;

	// escape markers
	localparam logic [7:0]  ESCAPE_8  = 8'h80;
	localparam logic [15:0] ESCAPE_16 = 16'h8000;
	localparam logic [31:0] ESCAPE_32 = 32'h8000_0000;

	// byte positions inside the wide deltas
	localparam logic [2:0] IDX_FIRST    = 3'd0;
	localparam logic [2:0] IDX_SECOND   = 3'd1;
	localparam logic [2:0] IDX_32_LAST  = 3'd3;
	localparam logic [2:0] IDX_64_HIGH  = 3'd4;
	localparam logic [2:0] IDX_64_LAST  = 3'd7;

	// register map: address bit 2 selects the register
	localparam logic REG_ELEMENT_COUNT = 1'b0;

endpackage

`default_nettype wire

[hw/rtl/byte_offset_delta_decoder.sv]
// ----------------------------------------------------------------------------
// byte_offset_delta_decoder
// rebuilds 32-bit signed pixels from a byte-offset compressed byte stream
// ----------------------------------------------------------------------------
// One compressed byte is taken per clock cycle, every cycle, as long as the
// delta queue has room; the queue only fills when the output side stalls.
// A byte that completes a delta produces one pixel, held first in the delta
// queue and then in the output register. Escape bytes and partial wide
// deltas produce no word. The pixel rate is set by the single 32-bit add of
// the accumulator, one pixel per cycle while the output side does not stall.
// element_count (register 0, byte address 0) sets the pixels per array;
// after the last pixel the running sum and pixel count return to zero.
// Write it only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_offset_delta_decoder #(
	parameter int QUEUE_DEPTH = 4   // delta words buffered between parser and accumulator
) (
	input  wire logic         clk,
	input  wire logic         arst_n,

	// apb-style configuration port
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready,

	// compressed byte input
	input  wire logic         in_valid,
	output logic              in_stall,
	input  wire logic [7:0]   data_byte,

	// pixel output
	output logic              out_valid,
	input  wire logic         out_stall,
	output logic signed [31:0] pixel_value,
	output logic              last_pixel
);

	// configuration register
	logic [bod_pkg::COUNT_W-1:0] element_count_q;
	logic                        cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			element_count_q <= bod_pkg::COUNT_MIN;
		end else if (cfg_write && (paddr[2] == bod_pkg::REG_ELEMENT_COUNT)) begin
			element_count_q <= pwdata[bod_pkg::COUNT_W-1:0];
		end
	end

	// read back; unmapped address reads zero
	assign prdata = (paddr[2] == bod_pkg::REG_ELEMENT_COUNT)
		? {{(32 - bod_pkg::COUNT_W){1'b0}}, element_count_q} : 32'd0;

	// front: byte parser, stalls only on a full queue
	bod_pkg::delta_word_t front_word;
	bod_pkg::delta_word_t head_word;
	logic                 queue_full;
	logic                 take_byte;
	logic                 pop;

	assign in_stall  = queue_full;
	assign take_byte = in_valid && !in_stall;

	bod_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take_byte),
		.data_byte (data_byte),
		.word      (front_word)
	);

	// queue of finished deltas, lets parser and accumulator stall separately
	bod_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_word (front_word),
		.pop       (pop),
		.head      (head_word),
		.full      (queue_full)
	);

	// back: running sum, array count, registered output word
	bod_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head_word),
		.element_count (element_count_q),
		.out_stall     (out_stall),
		.pop           (pop),
		.pixel_value   (pixel_value),
		.last_pixel    (last_pixel),
		.out_valid     (out_valid)
	);

endmodule

`default_nettype wire

[hw/rtl/bod_front.sv]
// ----------------------------------------------------------------------------
// bod_front
// byte parser: follows the escape levels and gathers little-endian deltas
// ----------------------------------------------------------------------------
`default_nettype none

module bod_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                take,
	input  wire logic [7:0]          data_byte,
	output bod_pkg::delta_word_t     word
);

	bod_pkg::esc_level_t lvl_q, lvl_d;
	logic [2:0]          idx_q, idx_d;
	bod_pkg::delta_t     gath_q, gath_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q  <= bod_pkg::ESC_8;
			idx_q  <= bod_pkg::IDX_FIRST;
			gath_q <= '0;
		end else begin
			lvl_q  <= lvl_d;
			idx_q  <= idx_d;
			gath_q <= gath_d;
		end
	end

	bod_pkg::delta_t lane;
	bod_pkg::delta_t gath_new;
	logic [15:0]     v16;

	always_comb begin
		lane     = {24'd0, data_byte} << {idx_q[1:0], 3'b000};
		gath_new = gath_q | lane;
		v16      = {data_byte, gath_q[7:0]};
		lvl_d    = lvl_q;
		idx_d    = idx_q;
		gath_d   = gath_q;
		word     = '0;
		if (take) begin
			case (lvl_q)
				bod_pkg::ESC_8: begin
					if (data_byte == bod_pkg::ESCAPE_8) begin
						lvl_d  = bod_pkg::ESC_16;
						idx_d  = bod_pkg::IDX_FIRST;
						gath_d = '0;
					end else begin
						word.valid = 1'b1;
						word.delta = {{24{data_byte[7]}}, data_byte};
					end
				end
				bod_pkg::ESC_16: begin
					if (idx_q == bod_pkg::IDX_FIRST) begin
						gath_d = {24'd0, data_byte};
						idx_d  = bod_pkg::IDX_SECOND;
					end else if (v16 == bod_pkg::ESCAPE_16) begin
						lvl_d  = bod_pkg::ESC_32;
						idx_d  = bod_pkg::IDX_FIRST;
						gath_d = '0;
					end else begin
						word.valid = 1'b1;
						word.delta = {{16{v16[15]}}, v16};
					end
				end
				bod_pkg::ESC_32: begin
					if (idx_q < bod_pkg::IDX_32_LAST) begin
						gath_d = gath_new;
						idx_d  = idx_q + 3'd1;
					end else if (gath_new == bod_pkg::ESCAPE_32) begin
						lvl_d  = bod_pkg::ESC_64;
						idx_d  = bod_pkg::IDX_FIRST;
						gath_d = '0;
					end else begin
						word.valid = 1'b1;
						word.delta = gath_new;
					end
				end
				bod_pkg::ESC_64: begin
					// high half of the 64-bit delta is dropped
					if (idx_q < bod_pkg::IDX_64_HIGH) begin
						gath_d = gath_new;
					end
					if (idx_q < bod_pkg::IDX_64_LAST) begin
						idx_d = idx_q + 3'd1;
					end else begin
						word.valid = 1'b1;
						word.delta = gath_q;
					end
				end
				default: begin
					lvl_d = bod_pkg::ESC_8;
				end
			endcase
			if (word.valid) begin
				lvl_d  = bod_pkg::ESC_8;
				idx_d  = bod_pkg::IDX_FIRST;
				gath_d = '0;
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/bod_queue.sv]
// ----------------------------------------------------------------------------
// bod_queue
// short fifo of finished deltas between parser and accumulator
// ----------------------------------------------------------------------------
`default_nettype none

module bod_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire bod_pkg::delta_word_t push_word,
	input  wire logic                pop,
	output bod_pkg::delta_word_t     head,
	output logic                     full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	bod_pkg::delta_t  mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CNT_FULL);
	assign head    = '{valid: (cnt_q != '0), delta: mem[rd_ptr_q]};
	assign do_push = push_word.valid && !full;
	assign do_pop  = pop && head.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_word.delta;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/bod_back.sv]
// ----------------------------------------------------------------------------
// bod_back
// accumulator: running sum, pixel count and output register
// ----------------------------------------------------------------------------
`default_nettype none

module bod_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire bod_pkg::delta_word_t          head,
	input  wire logic [bod_pkg::COUNT_W-1:0]   element_count,
	input  wire logic                          out_stall,
	output logic                               pop,
	output logic signed [31:0]                 pixel_value,
	output logic                               last_pixel,
	output logic                               out_valid
);

	bod_pkg::delta_t               sum_q;
	logic [bod_pkg::PIXELS_W-1:0]  done_q;
	logic                          valid_q;
	bod_pkg::delta_t               pixel_q;
	logic                          last_q;

	logic [bod_pkg::COUNT_W-1:0]   limit;
	logic [bod_pkg::COUNT_W-1:0]   done_inc;
	bod_pkg::delta_t               sum_next;
	logic                          is_last;

	always_comb begin
		if (element_count == '0) begin
			limit = bod_pkg::COUNT_MIN;
		end else if (element_count > bod_pkg::COUNT_MAX) begin
			limit = bod_pkg::COUNT_MAX;
		end else begin
			limit = element_count;
		end
	end

	assign done_inc = {1'b0, done_q} + bod_pkg::COUNT_W'(1);
	assign is_last  = (done_inc >= limit);
	assign sum_next = sum_q + head.delta;
	assign pop      = head.valid && (!valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			done_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (pop) begin
				valid_q <= 1'b1;
				if (is_last) begin
					sum_q  <= '0;
					done_q <= '0;
				end else begin
					sum_q  <= sum_next;
					done_q <= done_inc[bod_pkg::PIXELS_W-1:0];
				end
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			pixel_q <= sum_next;
			last_q  <= is_last;
		end
	end

	assign pixel_value = pixel_q;
	assign last_pixel  = last_q;
	assign out_valid   = valid_q;

endmodule

`default_nettype wire

[tb/bod_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bod_checker
// pixel predictor and scoreboard for the byte-offset delta decoder
// ----------------------------------------------------------------------------
// Watches the byte, pixel and register ports. Every accepted byte runs
// through a local copy of the escape parser and running sum; each finished
// pixel is queued and compared with the next pixel word leaving the block.
// Register writes update the local element count, register reads are
// checked against it.
// ----------------------------------------------------------------------------

module bod_checker (
	input  wire logic         clk,
	input  wire logic         arst_n,

	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	input  wire logic [31:0]  prdata,
	input  wire logic         pready,

	input  wire logic         in_valid,
	input  wire logic         in_stall,
	input  wire logic [7:0]   data_byte,

	input  wire logic         out_valid,
	input  wire logic         out_stall,
	input  wire logic [31:0]  pixel_value,
	input  wire logic         last_pixel,

	output int                mismatches,
	output int                pending_words,
	output int                pixels_checked,
	output int                arrays_closed
);

	typedef struct packed {
		logic [31:0] pixel;
		logic        last_flag;
	} pixel_word_t;

	pixel_word_t                   expected_pixels[$];

	bod_pkg::esc_level_t           esc;
	logic [2:0]                    byte_pos;
	logic [31:0]                   gather;
	logic [31:0]                   running_sum;
	logic [bod_pkg::PIXELS_W-1:0]  pixels_done;
	logic [bod_pkg::COUNT_W-1:0]   element_count;
	int                            error_count;

	assign mismatches = error_count;

	task automatic report(input string what);
		error_count++;
		if (error_count <= 100) begin
			$display("%0t ns: %s", $time, what);
		end
	endtask

	// add the delta, queue the pixel, close the array when the count is reached
	task automatic close_pixel(input logic [31:0] delta);
		logic [bod_pkg::COUNT_W-1:0] limit;
		logic                        closes;
		limit = element_count;
		if (limit == '0) begin
			limit = bod_pkg::COUNT_MIN;
		end
		if (limit > bod_pkg::COUNT_MAX) begin
			limit = bod_pkg::COUNT_MAX;
		end
		running_sum = running_sum + delta;
		closes = ({1'b0, pixels_done} + 1'b1) >= limit;
		expected_pixels.push_back('{pixel: running_sum, last_flag: closes});
		esc = bod_pkg::ESC_8;
		byte_pos = bod_pkg::IDX_FIRST;
		gather = '0;
		if (closes) begin
			running_sum = '0;
			pixels_done = '0;
		end else begin
			pixels_done = pixels_done + 1'b1;
		end
	endtask

	task automatic decode_byte(input logic [7:0] b);
		logic [15:0] half;
		logic [31:0] shifted;
		shifted = {24'b0, b} << (8 * byte_pos[1:0]);
		case (esc)
			bod_pkg::ESC_8: begin
				if (b == bod_pkg::ESCAPE_8) begin
					esc = bod_pkg::ESC_16;
					byte_pos = bod_pkg::IDX_FIRST;
					gather = '0;
				end else begin
					close_pixel({{24{b[7]}}, b});
				end
			end
			bod_pkg::ESC_16: begin
				if (byte_pos == bod_pkg::IDX_FIRST) begin
					gather = {24'b0, b};
					byte_pos = bod_pkg::IDX_SECOND;
				end else begin
					half = {b, gather[7:0]};
					if (half == bod_pkg::ESCAPE_16) begin
						esc = bod_pkg::ESC_32;
						byte_pos = bod_pkg::IDX_FIRST;
						gather = '0;
					end else begin
						close_pixel({{16{half[15]}}, half});
					end
				end
			end
			bod_pkg::ESC_32: begin
				gather = gather | shifted;
				if (byte_pos < bod_pkg::IDX_32_LAST) begin
					byte_pos = byte_pos + 3'd1;
				end else if (gather == bod_pkg::ESCAPE_32) begin
					esc = bod_pkg::ESC_64;
					byte_pos = bod_pkg::IDX_FIRST;
					gather = '0;
				end else begin
					close_pixel(gather);
				end
			end
			default: begin
				// upper four bytes of a 64-bit delta are dropped
				if (byte_pos < bod_pkg::IDX_64_HIGH) begin
					gather = gather | shifted;
				end
				if (byte_pos < bod_pkg::IDX_64_LAST) begin
					byte_pos = byte_pos + 3'd1;
				end else begin
					close_pixel(gather);
				end
			end
		endcase
	endtask

	task automatic check_pixel();
		pixel_word_t want;
		if (expected_pixels.size() == 0) begin
			report($sformatf("pixel %0d (last %b) with no word pending",
				$signed(pixel_value), last_pixel));
		end else begin
			want = expected_pixels.pop_front();
			if (pixel_value !== want.pixel) begin
				report($sformatf("pixel_value %0d, predicted %0d",
					$signed(pixel_value), $signed(want.pixel)));
			end
			if (last_pixel !== want.last_flag) begin
				report($sformatf("last_pixel %b, predicted %b", last_pixel, want.last_flag));
			end
			pixels_checked++;
			if (want.last_flag) begin
				arrays_closed++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_pixels.delete();
			esc = bod_pkg::ESC_8;
			byte_pos = bod_pkg::IDX_FIRST;
			gather = '0;
			running_sum = '0;
			pixels_done = '0;
			element_count = bod_pkg::COUNT_MIN;
			error_count = 0;
			pixels_checked = 0;
			arrays_closed = 0;
			pending_words <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				check_pixel();
			end
			if (psel && penable && pready && paddr[2] == bod_pkg::REG_ELEMENT_COUNT) begin
				if (pwrite) begin
					element_count = pwdata[bod_pkg::COUNT_W-1:0];
				end else if (prdata !== 32'(element_count)) begin
					report($sformatf("element_count reads %0d, holds %0d", prdata, element_count));
				end
			end
			if (in_valid && !in_stall) begin
				decode_byte(data_byte);
			end
			pending_words <= expected_pixels.size();
		end
	end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// byte stream stimulus and verdict for the byte-offset delta decoder
// ----------------------------------------------------------------------------
// A short directed stream hits the one-byte extremes and the 16- and 64-bit
// escape widths, then random phases send mostly well-formed wide deltas
// mixed with raw bytes, each phase under a new element count (zero, one,
// small, past the 2^24 ceiling, changed mid-array). Both ports idle in short
// random bursts; one phase holds the pixel side off long enough to back up
// the byte input. bod_checker predicts and compares every pixel word.
// ----------------------------------------------------------------------------

module tb;

	localparam int         CYCLE_LIMIT  = 200000;
	localparam int         HOLD_CYCLES  = 64;     // long output hold, fills the delta queue
	localparam int         DRAIN_CYCLES = 8;      // pipeline depth plus margin
	localparam int         PHASES       = 8;
	localparam int         PHASE_BYTES  = 60;
	localparam logic [2:0] COUNT_ADDR   = {bod_pkg::REG_ELEMENT_COUNT, 2'b00};

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [2:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid;
	logic               in_stall;
	logic [7:0]         data_byte;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] pixel_value;
	logic               last_pixel;

	// scoreboard status
	int mismatches;
	int pending_words;
	int pixels_checked;
	int arrays_closed;

	// idling knobs, changed per phase
	bit send_gaps;
	bit recv_stalls;
	bit hold_request;

	int bytes_sent;
	int pushback_cycles;
	int cycles;

	byte_offset_delta_decoder DUT (.*);

	bod_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d pixel words still pending",
			cycles, pending_words);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// count cycles where the byte input was pushed back
	always @(posedge clk) begin
		if (arst_n && in_valid && in_stall) begin
			pushback_cycles++;
		end
	end

	// pixel side: short random stalls, and one long hold on request
	initial begin
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else if (recv_stalls && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 3)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// one register access: setup, access until pready, then idle
	task automatic apb_access(input logic write, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= write;
		paddr <= COUNT_ADDR;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// offer one byte, optionally after a short gap, and wait until it is taken
	task automatic send_byte(input logic [7:0] b);
		if (send_gaps && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (in_stall);
		bytes_sent++;
	endtask

	// little-endian bytes of a value, lowest first
	task automatic send_le(input logic [31:0] value, input int count);
		for (int k = 0; k < count; k++) begin
			send_byte(value[8*k +: 8]);
		end
	endtask

	// escape bytes that switch the parser up to the given delta width
	task automatic send_wide_prefix(input bod_pkg::esc_level_t width);
		send_byte(bod_pkg::ESCAPE_8);
		if (width >= bod_pkg::ESC_32) begin
			send_le(32'(bod_pkg::ESCAPE_16), 2);
		end
		if (width == bod_pkg::ESC_64) begin
			send_le(bod_pkg::ESCAPE_32, 4);
		end
	endtask

	// deltas biased toward the sign and escape boundaries
	function automatic logic [31:0] pick_delta();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h7FFF_FFFF;
			3: return 32'h8000_0001;
			4: return 32'hFFFF_8001;
			5: return 32'h0000_7FFF;
			default: return $urandom;
		endcase
	endfunction

	// one encoded pixel of random width, or a short run of raw bytes
	task automatic send_random_pixel();
		int          pick;
		logic [31:0] delta;
		pick = $urandom_range(0, 99);
		delta = pick_delta();
		if (pick < 45) begin
			// raw bytes: mostly one-byte deltas, now and then a stray escape
			send_le($urandom, $urandom_range(1, 4));
		end else if (pick < 70) begin
			send_wide_prefix(bod_pkg::ESC_16);
			send_le(delta, 2);
		end else if (pick < 85) begin
			send_wide_prefix(bod_pkg::ESC_32);
			send_le(delta, 4);
		end else begin
			// 64-bit delta, upper half random
			send_wide_prefix(bod_pkg::ESC_64);
			send_le(delta, 4);
			send_le($urandom, 4);
		end
	endtask

	// stop offering, wait for every predicted word, then let the pipeline settle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_words != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// count for each random phase: zero, small, above the ceiling, one,
	// a long array cut short by the next setting, two, exactly 2^24, random
	function automatic logic [31:0] phase_count(input int phase);
		case (phase)
			0: return 32'd0;
			1: return 32'd3;
			2: return 32'hFFFF_FFFF;
			3: return 32'd1;
			4: return 32'd40;
			5: return 32'd2;
			6: return 32'h0100_0000;
			default: return $urandom_range(2, 12);
		endcase
	endfunction

	initial begin
		int phase_start;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		data_byte = '0;
		send_gaps = 1'b1;
		recv_stalls = 1'b1;
		hold_request = 1'b0;
		bytes_sent = 0;
		pushback_cycles = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed stream, five pixels per array
		apb_access(1'b1, 32'd5);
		apb_access(1'b0, '0);
		send_byte(8'h00);
		send_byte(8'h7F);       // largest positive one-byte delta
		send_byte(8'h81);       // most negative one-byte delta
		send_byte(8'hFF);
		send_wide_prefix(bod_pkg::ESC_16);
		send_le(32'h0000_7FFF, 2);
		send_wide_prefix(bod_pkg::ESC_64);
		send_le(32'h8000_0001, 4);
		send_le($urandom, 4);   // ignored high half
		drain();

		// random phases, each under a new count
		for (int phase = 0; phase < PHASES; phase++) begin
			apb_access(1'b1, phase_count(phase));
			apb_access(1'b0, '0);
			send_gaps = (phase % 3 != 1);
			recv_stalls = (phase % 3 != 2);
			if (phase == 4) begin
				// sender keeps offering while the pixel side is held
				send_gaps = 1'b0;
				hold_request = 1'b1;
			end
			if (phase == PHASES - 1) begin
				send_gaps = 1'b0;
				recv_stalls = 1'b0;
			end
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < PHASE_BYTES) begin
				send_random_pixel();
			end
			drain();
		end

		$display("run covered %0d bytes under %0d count settings: %0d pixels, %0d arrays",
			bytes_sent, PHASES + 1, pixels_checked, arrays_closed);
		$display("all delta widths, counts 0, 1 and past 2^24, %0d input stall cycles",
			pushback_cycles);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
